// File: src/nmea_sentence_checker_macros.svh
// Assertion macros for the NMEA sentence checker.
// Uses the clk and rst names of the module that includes it.
`ifndef NMEA_SENTENCE_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NMEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NMEA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NMEA_ASSERT(lbl, prop, msg)
`define NMEA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/nmea_pkg.sv
// Package for the NMEA sentence checker: byte classes, queue entry, status
// codes, character constants and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package nmea_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] MAX_SENTENCE_CHARS = 8'd255;
  localparam logic [7:0] MIN_CHARS_RESET    = 8'd7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] PRINT_LOW = 8'h20;
  localparam logic [7:0] PRINT_END = 8'h7F;

  typedef enum logic [2:0] {
    CLS_DOLLAR,
    CLS_TERM,
    CLS_STAR,
    CLS_PRINT,
    CLS_OTHER
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
  } rx_entry_t;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_FORMAT   = 2'd2
  } check_status_t;

  // {valid, value}; accepts 0-9, A-F, a-f
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: src/nmea_front.sv
// Front end: classifies each received byte and queues it for the back end.
// Depends on nmea_pkg.
`timescale 1ns / 1ps

module nmea_front #(
  parameter int unsigned DEPTH = nmea_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                q_valid,
  output nmea_pkg::rx_entry_t q_entry,
  input  logic                q_pop
);
  import nmea_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rx_entry_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  rx_entry_t        cls_entry;
  logic             push;
  logic             pop;

  always_comb begin
    cls_entry.data = rx_byte;
    if (rx_byte == CH_DOLLAR) begin
      cls_entry.cls = CLS_DOLLAR;
    end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
      cls_entry.cls = CLS_TERM;
    end else if (rx_byte == CH_STAR) begin
      cls_entry.cls = CLS_STAR;
    end else if (rx_byte >= PRINT_LOW && rx_byte < PRINT_END) begin
      cls_entry.cls = CLS_PRINT;
    end else begin
      cls_entry.cls = CLS_OTHER;
    end
  end

  assign in_ready = (fill != CNT_W'(DEPTH));
  assign q_valid  = (fill != '0);
  assign q_entry  = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_pop;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: src/nmea_back.sv
// Back end: sentence framing, running XOR, checksum verdict and result register.
// Depends on nmea_pkg.
`timescale 1ns / 1ps

module nmea_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  nmea_pkg::rx_entry_t q_entry,
  output logic                q_pop,
  input  logic [7:0]          min_chars,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [7:0]          computed_sum,
  output logic [7:0]          received_sum,
  output logic [7:0]          sentence_chars
);
  import nmea_pkg::*;

  logic       in_sentence,      in_sentence_next;
  logic [7:0] char_count,       char_count_next;
  logic [7:0] running_xor,      running_xor_next;
  logic [7:0] xor_at_star,      xor_at_star_next;
  logic       star_seen,        star_seen_next;
  logic [1:0] chars_after_star, chars_after_star_next;
  logic [7:0] first_digit,      first_digit_next;
  logic [7:0] second_digit,     second_digit_next;

  logic          advance;
  logic          emit;
  logic [7:0]    c;
  logic [4:0]    h1;
  logic [4:0]    h2;
  check_status_t vd_status;
  logic [7:0]    vd_comp;
  logic [7:0]    vd_recv;

  assign advance = q_valid && (!out_valid || out_ready);
  assign q_pop   = advance;
  assign c       = q_entry.data;

  // verdict from the state as it stands when the terminator arrives
  always_comb begin
    h1        = hex_digit(first_digit);
    h2        = hex_digit(second_digit);
    vd_status = ST_FORMAT;
    vd_comp   = 8'd0;
    vd_recv   = 8'd0;
    if (star_seen) begin
      vd_comp = xor_at_star;
      if (chars_after_star[1] && h1[4]) begin
        vd_recv   = h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]};
        vd_status = (vd_recv == xor_at_star) ? ST_MATCH : ST_MISMATCH;
      end
    end
  end

  always_comb begin
    in_sentence_next      = in_sentence;
    char_count_next       = char_count;
    running_xor_next      = running_xor;
    xor_at_star_next      = xor_at_star;
    star_seen_next        = star_seen;
    chars_after_star_next = chars_after_star;
    first_digit_next      = first_digit;
    second_digit_next     = second_digit;
    emit                  = 1'b0;
    if (advance) begin
      if (q_entry.cls == CLS_DOLLAR) begin
        // dollar restarts and is stored as character one
        in_sentence_next      = 1'b1;
        char_count_next       = 8'd1;
        running_xor_next      = 8'd0;
        xor_at_star_next      = 8'd0;
        star_seen_next        = 1'b0;
        chars_after_star_next = 2'd0;
        first_digit_next      = 8'd0;
        second_digit_next     = 8'd0;
      end else if (in_sentence) begin
        unique case (q_entry.cls)
          CLS_TERM: begin
            in_sentence_next = 1'b0;
            emit             = (char_count >= min_chars);
          end
          default: begin
            if (char_count < MAX_SENTENCE_CHARS) begin
              if (q_entry.cls == CLS_STAR) begin
                xor_at_star_next      = running_xor;
                star_seen_next        = 1'b1;
                chars_after_star_next = 2'd0;
                first_digit_next      = 8'd0;
                second_digit_next     = 8'd0;
              end else if (q_entry.cls == CLS_PRINT && star_seen) begin
                if (chars_after_star == 2'd0) begin
                  first_digit_next = c;
                end else if (chars_after_star == 2'd1) begin
                  second_digit_next = c;
                end
                if (!chars_after_star[1]) begin
                  chars_after_star_next = chars_after_star + 2'd1;
                end
              end
              if (q_entry.cls == CLS_STAR || q_entry.cls == CLS_PRINT) begin
                running_xor_next = running_xor ^ c;
                char_count_next  = char_count + 8'd1;
              end
            end else begin
              // overflow drops the sentence
              in_sentence_next = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence      <= 1'b0;
      char_count       <= 8'd0;
      running_xor      <= 8'd0;
      xor_at_star      <= 8'd0;
      star_seen        <= 1'b0;
      chars_after_star <= 2'd0;
      first_digit      <= 8'd0;
      second_digit     <= 8'd0;
      out_valid        <= 1'b0;
    end else begin
      in_sentence      <= in_sentence_next;
      char_count       <= char_count_next;
      running_xor      <= running_xor_next;
      xor_at_star      <= xor_at_star_next;
      star_seen        <= star_seen_next;
      chars_after_star <= chars_after_star_next;
      first_digit      <= first_digit_next;
      second_digit     <= second_digit_next;
      out_valid        <= emit || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status         <= vd_status;
      computed_sum   <= vd_comp;
      received_sum   <= vd_recv;
      sentence_chars <= char_count;
    end
  end

endmodule

// File: src/nmea_sentence_checker.sv
// Top level of the NMEA sentence checker: config register, front, back.
// Depends on nmea_pkg, nmea_front, nmea_back and the assertion macro header.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  status, computed_sum, received_sum,
//                                    sentence_chars
//   config    cfg_wr_en              cfg_wr_data (min_sentence_chars)
//
// One byte per cycle unless stalled; a byte is registered in the queue before
// the back end sees it; a verdict is seen the cycle after its terminator leaves
// the queue. The queue (QUEUE_DEPTH entries) absorbs output stalls; the back
// end pops only when the result register is empty or being read.
// Reset clears framing state, queue and result valid; min_sentence_chars = 7.
`timescale 1ns / 1ps
`include "nmea_sentence_checker_macros.svh"

module nmea_sentence_checker #(
  parameter int unsigned QUEUE_DEPTH = nmea_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [1:0] status,
  output logic [7:0] computed_sum,
  output logic [7:0] received_sum,
  output logic [7:0] sentence_chars,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import nmea_pkg::*;

  logic      [7:0] min_chars;
  logic            q_valid;
  logic            q_pop;
  rx_entry_t       q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_chars <= MIN_CHARS_RESET;
    end else if (cfg_wr_en) begin
      min_chars <= cfg_wr_data;
    end
  end

  nmea_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  nmea_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .min_chars      (min_chars),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .computed_sum   (computed_sum),
    .received_sum   (received_sum),
    .sentence_chars (sentence_chars)
  );

  `NMEA_ASSERT(a_status_code, out_valid |-> (status == ST_MATCH || status == ST_MISMATCH || status == ST_FORMAT), "undefined status code")
  `NMEA_ASSERT(a_match_equal, (out_valid && status == ST_MATCH) |-> (computed_sum == received_sum), "match with differing sums")
  `NMEA_ASSERT(a_mismatch_differ, (out_valid && status == ST_MISMATCH) |-> (computed_sum != received_sum), "mismatch with equal sums")
  `NMEA_ASSERT(a_min_length, out_valid |-> (sentence_chars >= min_chars), "verdict for a short sentence")
  `NMEA_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "result valid after reset")

endmodule
